FILE: sv/memory_region_table_defines.svh
// Assertion macros for the memory region table RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MEMORY_REGION_TABLE_DEFINES_SVH
`define MEMORY_REGION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mrt_pkg.sv
// Shared types and codes for the memory region table.
// Used by mrt_cell and memory_region_table; no dependencies.
package mrt_pkg;

  localparam int ADDR_W = 64;
  localparam int REQ_W  = 3;
  localparam int ST_W   = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONTAIN = 3'd2;
  localparam logic [REQ_W-1:0] REQ_EXACT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // compare performed by every cell during a scan
  typedef enum logic [1:0] {
    SCAN_REMOVE,
    SCAN_CONTAIN,
    SCAN_EXACT
  } mrt_scan_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } mrt_tok_t;

endpackage

FILE: sv/mrt_cell.sv
// One table entry plus its stage of the search token chain.
// Depends on mrt_pkg.
module mrt_cell import mrt_pkg::*; #(
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mrt_scan_t               op,
  input  logic                    scan_start,
  input  logic [HANDLE_WIDTH-1:0] q_handle,
  input  logic [ADDR_W-1:0]       q_base,
  input  logic [ADDR_W-1:0]       q_len,
  input  logic [ADDR_W:0]         q_sum,
  input  logic                    in_use,
  input  logic                    is_last,
  input  logic                    wr_sel,
  input  logic                    commit,
  input  logic [HANDLE_WIDTH-1:0] wr_handle,
  input  logic [ADDR_W-1:0]       wr_base,
  input  logic [ADDR_W-1:0]       wr_len,
  input  mrt_tok_t                tok_in,
  input  logic [HANDLE_WIDTH-1:0] tin_handle,
  input  logic [HANDLE_WIDTH-1:0] tin_lhandle,
  input  logic [ADDR_W-1:0]       tin_lbase,
  input  logic [ADDR_W-1:0]       tin_llen,
  output mrt_tok_t                tok_out,
  output logic [HANDLE_WIDTH-1:0] tout_handle,
  output logic [HANDLE_WIDTH-1:0] tout_lhandle,
  output logic [ADDR_W-1:0]       tout_lbase,
  output logic [ADDR_W-1:0]       tout_llen,
  output logic                    mark
);

  logic [HANDLE_WIDTH-1:0] ent_handle;
  logic [ADDR_W-1:0]       ent_base;
  logic [ADDR_W-1:0]       ent_len;
  logic [ADDR_W:0]         ent_end;
  logic                    cmp_hit;
  logic                    hit;
  logic                    first;

  // end of region in 65 bits, never wraps
  assign ent_end = {1'b0, ent_base} + {1'b0, ent_len};

  always_comb begin
    unique case (op)
      SCAN_REMOVE:  cmp_hit = (ent_handle == q_handle);
      SCAN_CONTAIN: cmp_hit = (ent_base <= q_base) && (ent_end >= q_sum);
      SCAN_EXACT:   cmp_hit = (ent_base == q_base) && (ent_len == q_len);
      default:      cmp_hit = 1'b0;
    endcase
  end

  assign hit   = in_use && cmp_hit;
  assign first = tok_in.valid && !tok_in.found && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      mark    <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.valid && (tok_in.found || hit);
      // set wins over clear: cell 0 may hit on the launch edge
      if (first && op == SCAN_REMOVE) begin
        mark <= 1'b1;
      end else if (scan_start) begin
        mark <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tout_handle <= first ? ent_handle : tin_handle;
    if (is_last) begin
      tout_lhandle <= ent_handle;
      tout_lbase   <= ent_base;
      tout_llen    <= ent_len;
    end else begin
      tout_lhandle <= tin_lhandle;
      tout_lbase   <= tin_lbase;
      tout_llen    <= tin_llen;
    end
    if (wr_sel || (commit && mark)) begin
      ent_handle <= wr_handle;
      ent_base   <= wr_base;
      ent_len    <= wr_len;
    end
  end

endmodule

FILE: sv/memory_region_table.sv
// Memory region table top level: request sequencer over a chain of entry cells.
// Depends on mrt_pkg, mrt_cell and memory_region_table_defines.svh.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  request  | req_valid/req_stall | req_type, region_handle, base_addr, region_length
//  response | rsp_valid/rsp_stall | status, match_handle, entry_count
//
// Insert, clear, unused codes and searches of an empty table: the result is registered
//   from EXEC once the response register is free, and the sequencer returns to IDLE.
// Remove and both finds: the request passes EXEC, SCAN and FINISH before its result is
//   registered; a search token walks the cell chain one cell per cycle, so the chain
//   length sets the scan time.
// One request is in flight at a time; the next transfer is taken once the result
//   sits in the response register, even while rsp_stall holds it there.
// Reset clears the entry count and control state only; entry contents stay
//   undefined and are never read above the count, so there is no clearing pass.
`include "memory_region_table_defines.svh"

module memory_region_table import mrt_pkg::*; #(
  parameter int TABLE_DEPTH  = 64,
  parameter int HANDLE_WIDTH = 16,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [REQ_W-1:0]        req_type,
  input  logic [HANDLE_WIDTH-1:0] region_handle,
  input  logic [ADDR_W-1:0]       base_addr,
  input  logic [ADDR_W-1:0]       region_length,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [ST_W-1:0]         status,
  output logic [HANDLE_WIDTH-1:0] match_handle,
  output logic [CNT_W-1:0]        entry_count
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SCAN,
    FINISH
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;

  // request held for the whole operation, broadcast to every cell
  logic [REQ_W-1:0]        q_req;
  logic [HANDLE_WIDTH-1:0] q_handle;
  logic [ADDR_W-1:0]       q_base;
  logic [ADDR_W-1:0]       q_len;
  logic [ADDR_W:0]         q_sum;

  // token result captured at the end of the chain
  logic                    r_found;
  logic [HANDLE_WIDTH-1:0] r_handle;
  logic [HANDLE_WIDTH-1:0] r_lhandle;
  logic [ADDR_W-1:0]       r_lbase;
  logic [ADDR_W-1:0]       r_llen;

  logic                    out_free;
  logic                    rsp_load;
  logic                    full;
  logic                    scan_req;
  logic                    launch;
  logic                    ins_wr;
  logic                    commit;
  mrt_scan_t               scan_op;
  logic [ST_W-1:0]         exec_status;
  logic [CNT_W-1:0]        exec_count;
  logic [CNT_W-1:0]        last_cnt;
  logic [IDX_W-1:0]        wr_idx;
  logic [HANDLE_WIDTH-1:0] wr_handle;
  logic [ADDR_W-1:0]       wr_base;
  logic [ADDR_W-1:0]       wr_len;

  // chain links: entry k feeds link k+1
  mrt_tok_t                tok   [TABLE_DEPTH+1];
  logic [HANDLE_WIDTH-1:0] th    [TABLE_DEPTH+1];
  logic [HANDLE_WIDTH-1:0] tlh   [TABLE_DEPTH+1];
  logic [ADDR_W-1:0]       tlb   [TABLE_DEPTH+1];
  logic [ADDR_W-1:0]       tll   [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0]  mark_vec;
  mrt_tok_t                tok_end;

  assign req_stall = (state != IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign last_cnt  = count - CNT_W'(1);
  assign wr_idx    = count[IDX_W-1:0];
  assign scan_req  = (q_req == REQ_REMOVE) || (q_req == REQ_CONTAIN) || (q_req == REQ_EXACT);

  // an empty table never needs a scan: the answer is "not found"
  assign launch = (state == EXEC) && scan_req && (count != '0);
  assign ins_wr = (state == EXEC) && out_free && (q_req == REQ_INSERT) && !full;
  // remove: last entry moves into the marked slot
  assign commit = (state == FINISH) && out_free && r_found && (q_req == REQ_REMOVE);
  // a new result enters the response register
  assign rsp_load = out_free && (((state == EXEC) && !launch) || (state == FINISH));

  // one shared write bus: insert writes the request, commit writes the old tail
  assign wr_handle = (state == FINISH) ? r_lhandle : q_handle;
  assign wr_base   = (state == FINISH) ? r_lbase   : q_base;
  assign wr_len    = (state == FINISH) ? r_llen    : q_len;

  always_comb begin
    unique case (q_req)
      REQ_REMOVE:  scan_op = SCAN_REMOVE;
      REQ_CONTAIN: scan_op = SCAN_CONTAIN;
      default:     scan_op = SCAN_EXACT;
    endcase
  end

  // results that need no scan
  always_comb begin
    exec_status = ST_NOT_FOUND;
    exec_count  = count;
    if (q_req == REQ_INSERT) begin
      if (full) begin
        exec_status = ST_FULL;
      end else begin
        exec_status = ST_OK;
        exec_count  = count + CNT_W'(1);
      end
    end else if (q_req == REQ_CLEAR) begin
      exec_status = ST_OK;
      exec_count  = '0;
    end
  end

  assign tok[0] = '{valid: launch, found: 1'b0};
  assign th[0]  = '0;
  assign tlh[0] = '0;
  assign tlb[0] = '0;
  assign tll[0] = '0;
  assign tok_end = tok[TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic in_use;
    logic is_last;
    logic wr_sel;

    assign in_use  = (CNT_W'(k) < count);
    assign is_last = (CNT_W'(k) == last_cnt);
    assign wr_sel  = ins_wr && (wr_idx == IDX_W'(k));

    mrt_cell #(
      .HANDLE_WIDTH(HANDLE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (scan_op),
      .scan_start  (launch),
      .q_handle    (q_handle),
      .q_base      (q_base),
      .q_len       (q_len),
      .q_sum       (q_sum),
      .in_use      (in_use),
      .is_last     (is_last),
      .wr_sel      (wr_sel),
      .commit      (commit),
      .wr_handle   (wr_handle),
      .wr_base     (wr_base),
      .wr_len      (wr_len),
      .tok_in      (tok[k]),
      .tin_handle  (th[k]),
      .tin_lhandle (tlh[k]),
      .tin_lbase   (tlb[k]),
      .tin_llen    (tll[k]),
      .tok_out     (tok[k+1]),
      .tout_handle (th[k+1]),
      .tout_lhandle(tlh[k+1]),
      .tout_lbase  (tlb[k+1]),
      .tout_llen   (tll[k+1]),
      .mark        (mark_vec[k])
    );
  end

  // sequencer, table count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // held while stalled, dropped once taken, set by a new result
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (launch) begin
            state <= SCAN;
          end else if (out_free) begin
            status       <= exec_status;
            match_handle <= '0;
            entry_count  <= exec_count;
            count        <= exec_count;
            state        <= IDLE;
          end
        end
        SCAN: begin
          if (tok_end.valid) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            status       <= r_found ? ST_OK : ST_NOT_FOUND;
            match_handle <= (r_found && q_req != REQ_REMOVE) ? r_handle : '0;
            entry_count  <= commit ? last_cnt : count;
            if (commit) begin
              count <= last_cnt;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == IDLE && req_valid) begin
      q_req    <= req_type;
      q_handle <= region_handle;
      q_base   <= base_addr;
      q_len    <= region_length;
      q_sum    <= {1'b0, base_addr} + {1'b0, region_length};
    end
    if (state == SCAN && tok_end.valid) begin
      r_found   <= tok_end.found;
      r_handle  <= th[TABLE_DEPTH];
      r_lhandle <= tlh[TABLE_DEPTH];
      r_lbase   <= tlb[TABLE_DEPTH];
      r_llen    <= tll[TABLE_DEPTH];
    end
  end

  `MRT_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH), "count above depth")
  `MRT_ASSERT_SAME(a_tok_scan, clk, rst, tok_end.valid, state == SCAN, "token left chain outside scan")
  `MRT_ASSERT_SAME(a_one_mark, clk, rst, 1'b1, $onehot0(mark_vec), "more than one cell marked")
  `MRT_ASSERT_NEXT(a_remove_dec, clk, rst, commit, count + CNT_W'(1) == $past(count), "remove count")
  `MRT_ASSERT_SAME(a_rsp_src, clk, rst, $rose(rsp_valid), $past(state) == EXEC || $past(state) == FINISH, "stray response")

endmodule
